/* design/mbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types, constants and averaging functions of the 2x2 mipmap
// box-filter downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int MAX_DST_WIDTH = 2048;
    localparam int MAX_DST_ROWS  = 2048;
    localparam int PIXEL_W       = 32;
    localparam int PAIR_W        = 2 * PIXEL_W;
    localparam int MASK_W        = 24;
    localparam int SIZE_W        = 12;
    localparam int ROW_CNT_W     = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int SPREAD_SHIFT  = 14;

    localparam logic [MASK_W-1:0] BYTE_MODE_MASK = 24'hff00ff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_MASK = 2'd0,
        CFG_DST_WIDTH    = 2'd1,
        CFG_DST_HEIGHT   = 2'd2
    } cfg_index_t;

    // per-byte truncated average of four pixels
    function automatic logic [PIXEL_W-1:0] avg_bytes(
        input logic [PIXEL_W-1:0] a,
        input logic [PIXEL_W-1:0] b,
        input logic [PIXEL_W-1:0] c,
        input logic [PIXEL_W-1:0] d
    );
        logic [PIXEL_W-1:0] r;
        logic [9:0]         s;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            s = 10'(a[8*i +: 8]) + 10'(b[8*i +: 8]) + 10'(c[8*i +: 8]) + 10'(d[8*i +: 8]);
            r[8*i +: 8] = s[9:2];
        end
        return r;
    endfunction

    function automatic logic [31:0] spread16(
        input logic [15:0] v,
        input logic [15:0] m
    );
        return {16'b0, v & m} | ({16'b0, v & ~m} << SPREAD_SHIFT);
    endfunction

    // packed 16-bit average: fields outside the mask are moved up before summing
    function automatic logic [15:0] avg_packed(
        input logic [15:0] a,
        input logic [15:0] b,
        input logic [15:0] c,
        input logic [15:0] d,
        input logic [15:0] m
    );
        logic [31:0] sum;
        sum = spread16(a, m) + spread16(b, m) + spread16(c, m) + spread16(d, m);
        return (sum[17:2] & m) | (sum[31:16] & ~m);
    endfunction

endpackage

/* design/mbd_line_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_line_store
// Single-port-write, registered-read memory holding the even row's
// left/right pixel pairs.
// ----------------------------------------------------------------------------
module mbd_line_store #(
    parameter int DEPTH  = mbd_pkg::MAX_DST_WIDTH,
    parameter int ADDR_W = 11
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [mbd_pkg::PAIR_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [mbd_pkg::PAIR_W-1:0]  rd_data
);

    logic [mbd_pkg::PAIR_W-1:0] mem [DEPTH];
    logic [mbd_pkg::PAIR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/mipmap_box_downsample_2x2_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_2x2_core
// 2x2 box-filter mipmap downsampler: source pixels in raster order in,
// one averaged destination pixel per 2x2 block out.
//
// Usage:
//   s_* carries source pixels, 2*dst_width per row, 2*dst_height rows per
//   frame. m_* carries destination pixels with tlast on the last pixel of a
//   row and tuser on the last pixel of the frame. The cfg_* write port sets
//   channel_mask, dst_width and dst_height; write it only while idle.
//   One source pixel is taken per cycle unless input is held off. A result
//   passes from the transaction carrying the lower-right pixel of its block
//   through the registered line store read and then the output register.
//   When the receiver stalls, one result waits in the output register and a
//   second one in the read stage; input is held off only when both are full.
//   Reset clears the position counters, held pixel and valid bits and sets
//   byte mode, width 1, height 1. The line store is not cleared: every entry
//   is written by an even row before the odd row reads it: no clearing needed.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_2x2_core #(
    parameter int MAX_DST_WIDTH = mbd_pkg::MAX_DST_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbd_pkg::MASK_W-1:0]    cfg_wdata,
    // source pixels
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // [31:0] src_pixel
    // destination pixels
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // [31:0] dst_pixel
    output logic                          m_tlast,  // last_in_row
    output logic                          m_tuser   // [0] last_in_frame
);

    localparam int EFF_MAX = (MAX_DST_WIDTH < 4095) ? MAX_DST_WIDTH : 4095;
    localparam int COL_W   = $clog2(2 * EFF_MAX);
    localparam int ADDR_W  = (COL_W > 1) ? COL_W - 1 : 1;
    localparam int PW      = mbd_pkg::PIXEL_W;

    // configuration registers
    logic [mbd_pkg::MASK_W-1:0] channel_mask_reg;
    logic [mbd_pkg::SIZE_W-1:0] dst_width_reg;
    logic [mbd_pkg::SIZE_W-1:0] dst_height_reg;

    // position state
    logic [COL_W-1:0]              col_reg, col_next;
    logic                          odd_row_reg, odd_row_next;
    logic [mbd_pkg::ROW_CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [PW-1:0]                 held_left_reg;

    // read stage
    logic          s1_valid_reg, s1_valid_next;
    logic [PW-1:0] s1_left_reg;
    logic [PW-1:0] s1_right_reg;
    logic          s1_last_row_reg;
    logic          s1_last_frame_reg;

    // output stage
    logic          m_valid_reg;
    logic [PW-1:0] m_data_reg;
    logic          m_last_reg;
    logic          m_user_reg;

    logic                          accept;
    logic                          out_ready;
    logic                          s1_ready;
    logic [mbd_pkg::SIZE_W-1:0]    w_lim;
    logic [mbd_pkg::SIZE_W-1:0]    h_lim;
    logic [COL_W-1:0]              last_col;
    logic [mbd_pkg::ROW_CNT_W-1:0] last_row;
    logic [COL_W-1:0]              col_half;
    logic [ADDR_W-1:0]             pair_addr;
    logic                          odd_col;
    logic                          row_end;
    logic                          frame_end;
    logic                          store_wr;
    logic                          store_rd;
    logic [mbd_pkg::PAIR_W-1:0]    store_rd_data;
    logic [PW-1:0]                 upper_left;
    logic [PW-1:0]                 upper_right;
    logic [PW-1:0]                 avg_result;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_mask_reg <= mbd_pkg::BYTE_MODE_MASK;
            dst_width_reg    <= mbd_pkg::SIZE_W'(1);
            dst_height_reg   <= mbd_pkg::SIZE_W'(1);
        end else if (cfg_wr_en) begin
            unique case (mbd_pkg::cfg_index_t'(cfg_index))
                mbd_pkg::CFG_CHANNEL_MASK: channel_mask_reg <= cfg_wdata;
                mbd_pkg::CFG_DST_WIDTH:    dst_width_reg <= cfg_wdata[mbd_pkg::SIZE_W-1:0];
                mbd_pkg::CFG_DST_HEIGHT:   dst_height_reg <= cfg_wdata[mbd_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes
    always_comb begin
        if (dst_width_reg == '0) begin
            w_lim = mbd_pkg::SIZE_W'(1);
        end else if (dst_width_reg > mbd_pkg::SIZE_W'(EFF_MAX)) begin
            w_lim = mbd_pkg::SIZE_W'(EFF_MAX);
        end else begin
            w_lim = dst_width_reg;
        end
        if (dst_height_reg == '0) begin
            h_lim = mbd_pkg::SIZE_W'(1);
        end else if (dst_height_reg > mbd_pkg::SIZE_W'(mbd_pkg::MAX_DST_ROWS)) begin
            h_lim = mbd_pkg::SIZE_W'(mbd_pkg::MAX_DST_ROWS);
        end else begin
            h_lim = dst_height_reg;
        end
    end

    assign last_col = COL_W'({1'b0, w_lim, 1'b0} - 14'd1);
    assign last_row = mbd_pkg::ROW_CNT_W'(h_lim - mbd_pkg::SIZE_W'(1));

    // handshake
    assign out_ready = !m_valid_reg || m_tready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s_tready  = s1_ready;
    assign accept    = s_tvalid && s1_ready;

    // position decode
    assign col_half  = col_reg >> 1;
    assign pair_addr = ADDR_W'(col_half);
    assign odd_col   = col_reg[0];
    assign row_end   = odd_col && (col_reg >= last_col);
    assign frame_end = row_end && (row_cnt_reg >= last_row);
    assign store_wr  = accept && odd_col && !odd_row_reg;
    assign store_rd  = accept && odd_col && odd_row_reg;

    always_comb begin
        col_next     = col_reg;
        odd_row_next = odd_row_reg;
        row_cnt_next = row_cnt_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                if (odd_row_reg) begin
                    odd_row_next = 1'b0;
                    row_cnt_next = frame_end ? '0 : row_cnt_reg + 1'b1;
                end else begin
                    odd_row_next = 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            odd_row_reg   <= 1'b0;
            row_cnt_reg   <= '0;
            held_left_reg <= '0;
        end else begin
            col_reg     <= col_next;
            odd_row_reg <= odd_row_next;
            row_cnt_reg <= row_cnt_next;
            if (accept && !odd_col) begin
                held_left_reg <= s_tdata;
            end
        end
    end

    // even-row pairs; the odd row reads an entry at least a row after it is written
    mbd_line_store #(
        .DEPTH  (EFF_MAX),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (pair_addr),
        .wr_data ({s_tdata, held_left_reg}),
        .rd_en   (store_rd),
        .rd_addr (pair_addr),
        .rd_data (store_rd_data)
    );

    // read stage
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = store_rd;
        end else if (out_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_rd) begin
            s1_left_reg       <= held_left_reg;
            s1_right_reg      <= s_tdata;
            s1_last_row_reg   <= row_end;
            s1_last_frame_reg <= frame_end;
        end
    end

    // averaging
    assign upper_left  = store_rd_data[PW-1:0];
    assign upper_right = store_rd_data[mbd_pkg::PAIR_W-1:PW];

    always_comb begin
        if (channel_mask_reg == mbd_pkg::BYTE_MODE_MASK) begin
            avg_result = mbd_pkg::avg_bytes(upper_left, upper_right, s1_left_reg, s1_right_reg);
        end else begin
            avg_result = {16'b0, mbd_pkg::avg_packed(upper_left[15:0], upper_right[15:0],
                                                     s1_left_reg[15:0], s1_right_reg[15:0],
                                                     channel_mask_reg[15:0])};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s1_valid_reg) begin
            m_data_reg <= avg_result;
            m_last_reg <= s1_last_row_reg;
            m_user_reg <= s1_last_frame_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* design/mbd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_checker
// Port-level checks of the 2x2 mipmap downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module mbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                && $stable(m_tuser))
        else $error("stalled result changed");

    // frame end is always a row end
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without row end");

    // a new result follows an earlier input transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without source transaction");

    // reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind mipmap_box_downsample_2x2_core mbd_checker u_mbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2 box-filter mipmap downsampler. Source pixels
// go in through the stream slave port in raster order; a predictor inside the
// bench keeps its own line store, position counters and register copies and
// queues one expected destination pixel per 2x2 block. Every output
// transaction is compared field by field with the oldest expectation. The run
// covers byte and packed modes, masks at their extremes, sizes from the
// clamped minimum to above the maximum, register changes in mid-frame, random
// sender gaps, receiver stall patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_ITEMS  = 850;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 80;
    localparam logic [23:0] MASK_F81F     = 24'h00f81f;
    localparam logic [23:0] MASK_781F     = 24'h00781f;
    localparam logic [23:0] MASK_FC1F     = 24'h00fc1f;
    localparam logic [23:0] MASK_NONE     = 24'h000000;
    localparam logic [23:0] MASK_ALL      = 24'hffffff;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } rx_style_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic        row_last;
        logic        frame_last;
    } dst_item_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mbd_pkg::MASK_W-1:0]    cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [31:0]                   s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [31:0]                   m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;

    // predictor state and register copies
    logic [63:0]          pair_rows [0:mbd_pkg::MAX_DST_WIDTH-1];
    logic [31:0]          left_px;
    int                   src_col;
    logic                 on_odd_row;
    int                   dst_row;
    logic [23:0]          mask_reg;
    logic [11:0]          width_reg;
    logic [11:0]          height_reg;
    dst_item_t            expected_pixels [$];

    int                   errors;
    int                   items_sent;
    int                   results_checked;
    int                   reg_writes;
    int                   held_off;
    int                   cycle_count;
    int                   burst_left;
    logic                 tx_steady;
    rx_style_t            rx_mode;
    logic                 hold_request;
    int                   hold_left;
    int                   rx_phase;

    mipmap_box_downsample_2x2_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int active_width();
        if (width_reg == 12'd0) return 1;
        if (int'(width_reg) > mbd_pkg::MAX_DST_WIDTH) return mbd_pkg::MAX_DST_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        if (height_reg == 12'd0) return 1;
        if (int'(height_reg) > mbd_pkg::MAX_DST_ROWS) return mbd_pkg::MAX_DST_ROWS;
        return int'(height_reg);
    endfunction

    function automatic logic [31:0] mean_of_bytes(
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d
    );
        logic [31:0] r;
        logic [9:0]  s;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            s = {2'b0, a[8*i +: 8]} + {2'b0, b[8*i +: 8]}
              + {2'b0, c[8*i +: 8]} + {2'b0, d[8*i +: 8]};
            r[8*i +: 8] = s[9:2];
        end
        return r;
    endfunction

    // fields outside the mask move up 14 places so their carries stay apart
    function automatic logic [15:0] mean_of_fields(
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d,
        input logic [23:0] m
    );
        logic [31:0] quad [4];
        logic [63:0] mm;
        logic [63:0] outside;
        logic [63:0] v;
        logic [63:0] acc;
        logic [63:0] r;
        quad[0] = a;
        quad[1] = b;
        quad[2] = c;
        quad[3] = d;
        mm      = {40'b0, m};
        outside = ~mm & 64'h0000_0000_ffff_ffff;
        acc     = '0;
        for (int i = 0; i < 4; i++) begin
            v   = {48'b0, quad[i][15:0]};
            acc = acc + ((v & mm) | ((v & outside) << 14));
        end
        acc = acc >> 2;
        r   = (acc & mm) | ((acc >> 14) & outside);
        return r[15:0];
    endfunction

    task automatic track_pixel(input logic [31:0] px);
        int          w;
        int          h;
        int          idx;
        logic        row_end;
        logic [63:0] pair;
        dst_item_t   item;
        w   = active_width();
        h   = active_height();
        idx = src_col >> 1;
        if (src_col % 2 == 0) begin
            left_px = px;
            src_col++;
        end else begin
            row_end = (src_col >= 2 * w - 1);
            if (!on_odd_row) begin
                pair_rows[idx] = {px, left_px};
            end else begin
                pair = pair_rows[idx];
                if (mask_reg == mbd_pkg::BYTE_MODE_MASK) begin
                    item.pixel = mean_of_bytes(pair[31:0], pair[63:32], left_px, px);
                end else begin
                    item.pixel = {16'b0,
                                  mean_of_fields(pair[31:0], pair[63:32], left_px, px,
                                                 mask_reg)};
                end
                item.row_last   = row_end;
                item.frame_last = row_end && (dst_row >= h - 1);
                expected_pixels.push_back(item);
            end
            if (row_end) begin
                src_col = 0;
                if (on_odd_row) begin
                    on_odd_row = 1'b0;
                    if (dst_row >= h - 1) dst_row = 0;
                    else dst_row = (dst_row + 1) & 'h7ff;
                end else begin
                    on_odd_row = 1'b1;
                end
            end else begin
                src_col++;
            end
        end
    endtask

    function automatic logic [31:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] pick_mask();
        case ($urandom_range(0, 6))
            0:       return mbd_pkg::BYTE_MODE_MASK;
            1:       return MASK_F81F;
            2:       return MASK_781F;
            3:       return MASK_FC1F;
            4:       return MASK_NONE;
            5:       return MASK_ALL;
            default: return 24'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic push_pixel(input logic [31:0] px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap        = tx_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        track_pixel(px);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input mbd_pkg::cfg_index_t idx, input logic [23:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        reg_writes++;
        case (idx)
            mbd_pkg::CFG_CHANNEL_MASK: mask_reg   = value;
            mbd_pkg::CFG_DST_WIDTH:    width_reg  = value[11:0];
            mbd_pkg::CFG_DST_HEIGHT:   height_reg = value[11:0];
            default: ;
        endcase
    endtask

    task automatic send_frame();
        int n;
        n = 4 * active_width() * active_height();
        repeat (n) push_pixel(pick_pixel());
    endtask

    task automatic finish_frame();
        while (!(src_col == 0 && !on_odd_row && dst_row == 0)) push_pixel(pick_pixel());
    endtask

    task automatic test_directed_pixels();
        // byte mode after reset, single block frames
        repeat (4) push_pixel(32'hffff_ffff);
        push_pixel(32'h03ff_0100);
        push_pixel(32'h01ff_0001);
        push_pixel(32'h00ff_0002);
        push_pixel(32'h00fe_0000);
        drain();
        write_reg(mbd_pkg::CFG_CHANNEL_MASK, MASK_F81F);
        push_pixel(32'hffff_f81f);
        push_pixel(32'h0000_ffff);
        push_pixel(32'h1234_0001);
        push_pixel(32'hffff_07e0);
        drain();
        write_reg(mbd_pkg::CFG_CHANNEL_MASK, MASK_NONE);
        repeat (3) push_pixel(32'h0000_ffff);
        push_pixel(32'hffff_fffe);
        drain();
        write_reg(mbd_pkg::CFG_CHANNEL_MASK, MASK_ALL);
        push_pixel(32'hffff_ffff);
        push_pixel(32'h0000_0000);
        push_pixel(32'hffff_ffff);
        push_pixel(32'h0000_8001);
        drain();
        // zero sizes act as one
        write_reg(mbd_pkg::CFG_CHANNEL_MASK, mbd_pkg::BYTE_MODE_MASK);
        write_reg(mbd_pkg::CFG_DST_WIDTH, 24'd0);
        write_reg(mbd_pkg::CFG_DST_HEIGHT, 24'd0);
        push_pixel(32'h8080_8080);
        push_pixel(32'h7f7f_7f7f);
        push_pixel(32'h0102_0304);
        push_pixel(32'hfefd_fcfb);
        drain();
    endtask

    task automatic test_packed_masks();
        logic [23:0] masks [7];
        masks = '{mbd_pkg::BYTE_MODE_MASK, MASK_F81F, MASK_781F, MASK_FC1F, MASK_NONE,
                  MASK_ALL, 24'($urandom)};
        foreach (masks[i]) begin
            drain();
            write_reg(mbd_pkg::CFG_CHANNEL_MASK, masks[i]);
            write_reg(mbd_pkg::CFG_DST_WIDTH, 24'($urandom_range(1, 4)));
            write_reg(mbd_pkg::CFG_DST_HEIGHT, 24'($urandom_range(1, 2)));
            rx_mode = rx_style_t'($urandom_range(0, 3));
            send_frame();
        end
        drain();
    endtask

    // mode and size changes between pixels of a frame; a width raise is
    // only done on an even row so every line store read hits a written entry
    task automatic test_midframe_changes();
        int n;
        drain();
        write_reg(mbd_pkg::CFG_CHANNEL_MASK, mbd_pkg::BYTE_MODE_MASK);
        write_reg(mbd_pkg::CFG_DST_WIDTH, 24'd6);
        write_reg(mbd_pkg::CFG_DST_HEIGHT, 24'd3);
        repeat (16) begin
            n = $urandom_range(1, 15);
            repeat (n) push_pixel(pick_pixel());
            drain();
            case ($urandom_range(0, 2))
                0: write_reg(mbd_pkg::CFG_CHANNEL_MASK, pick_mask());
                1: begin
                    if (on_odd_row) begin
                        write_reg(mbd_pkg::CFG_DST_WIDTH,
                                  24'($urandom_range(1, active_width())));
                    end else begin
                        write_reg(mbd_pkg::CFG_DST_WIDTH, 24'($urandom_range(0, 10)));
                    end
                end
                default: write_reg(mbd_pkg::CFG_DST_HEIGHT, 24'($urandom_range(0, 5)));
            endcase
        end
        finish_frame();
        drain();
    endtask

    task automatic test_backpressure();
        drain();
        write_reg(mbd_pkg::CFG_CHANNEL_MASK, mbd_pkg::BYTE_MODE_MASK);
        write_reg(mbd_pkg::CFG_DST_WIDTH, 24'd4);
        write_reg(mbd_pkg::CFG_DST_HEIGHT, 24'd2);
        rx_mode      = RX_ALWAYS;
        tx_steady    = 1'b1;
        hold_request = 1'b1;
        send_frame();
        send_frame();
        tx_steady = 1'b0;
        drain();
    endtask

    task automatic test_largest_sizes();
        drain();
        tx_steady = 1'b1;
        // width above the maximum clamps to it; no row end within the first pixels,
        // then the width is cut back on the even row
        write_reg(mbd_pkg::CFG_CHANNEL_MASK, mbd_pkg::BYTE_MODE_MASK);
        write_reg(mbd_pkg::CFG_DST_WIDTH, 24'hfff);
        write_reg(mbd_pkg::CFG_DST_HEIGHT, 24'd1);
        rx_mode = RX_PATTERN;
        repeat (40) push_pixel(pick_pixel());
        drain();
        write_reg(mbd_pkg::CFG_DST_WIDTH, 24'd24);
        finish_frame();
        drain();
        // height above the maximum clamps to it; no frame end within eight rows,
        // then the height is cut back
        write_reg(mbd_pkg::CFG_CHANNEL_MASK, MASK_F81F);
        write_reg(mbd_pkg::CFG_DST_WIDTH, 24'd2);
        write_reg(mbd_pkg::CFG_DST_HEIGHT, 24'hfff);
        rx_mode = RX_ALWAYS;
        repeat (64) push_pixel(pick_pixel());
        drain();
        write_reg(mbd_pkg::CFG_DST_HEIGHT, 24'd3);
        finish_frame();
        tx_steady = 1'b0;
        drain();
    endtask

    task automatic test_random_frames();
        int first_item;
        int n;
        int cut;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            drain();
            write_reg(mbd_pkg::CFG_CHANNEL_MASK, pick_mask());
            write_reg(mbd_pkg::CFG_DST_WIDTH, ($urandom_range(0, 7) == 0)
                      ? 24'($urandom_range(0, 32)) : 24'($urandom_range(1, 8)));
            write_reg(mbd_pkg::CFG_DST_HEIGHT, ($urandom_range(0, 7) == 0)
                      ? 24'($urandom_range(0, 8)) : 24'($urandom_range(1, 4)));
            rx_mode   = rx_style_t'($urandom_range(0, 3));
            tx_steady = ($urandom_range(0, 3) == 0);
            n         = 4 * active_width() * active_height();
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, n - 1);
                repeat (cut) push_pixel(pick_pixel());
                drain();
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(mbd_pkg::CFG_CHANNEL_MASK, pick_mask());
                end else begin
                    write_reg(mbd_pkg::CFG_DST_HEIGHT, 24'($urandom_range(0, 4)));
                end
                finish_frame();
            end else begin
                repeat (n) push_pixel(pick_pixel());
            end
        end
        drain();
    endtask

    // receiver stall pattern, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_tready = 1'b1;
                RX_RANDOM:  m_tready = ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_tready = ((rx_phase % 11) < 7);
                default:    m_tready = ((rx_phase % 5) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && !s_tready) held_off++;
    end

    always @(posedge aclk) begin
        dst_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: transaction with nothing expected, actual %h tlast %b tuser %b",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                results_checked++;
                if (m_tdata !== want.pixel) begin
                    $display("%0t: dst_pixel expected %h actual %h", $time, want.pixel, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.row_last) begin
                    $display("%0t: last_in_row expected %b actual %b",
                             $time, want.row_last, m_tlast);
                    errors++;
                end
                if (m_tuser !== want.frame_last) begin
                    $display("%0t: last_in_frame expected %b actual %b",
                             $time, want.frame_last, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("mipmap_box_downsample_2x2_core: mismatch");
        $finish;
    end

    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = mbd_pkg::CFG_CHANNEL_MASK;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        left_px         = '0;
        src_col         = 0;
        on_odd_row      = 1'b0;
        dst_row         = 0;
        mask_reg        = mbd_pkg::BYTE_MODE_MASK;
        width_reg       = 12'd1;
        height_reg      = 12'd1;
        errors          = 0;
        items_sent      = 0;
        results_checked = 0;
        reg_writes      = 0;
        held_off        = 0;
        burst_left      = 0;
        tx_steady       = 1'b0;
        rx_mode         = RX_RANDOM;
        hold_request    = 1'b0;
        hold_left       = 0;
        rx_phase        = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed_pixels();
        test_packed_masks();
        test_midframe_changes();
        test_backpressure();
        test_largest_sizes();
        test_random_frames();
        drain();

        $display("covered %0d source pixels and %0d destination pixels in byte and packed modes",
                 items_sent, results_checked);
        $display("%0d register writes incl. clamped sizes and mid-frame changes, %0d stall cycles",
                 reg_writes, held_off);
        if (errors == 0) begin
            $display("mipmap_box_downsample_2x2_core: match");
        end else begin
            $display("mipmap_box_downsample_2x2_core: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
design/mbd_pkg.sv
design/mbd_line_store.sv
design/mipmap_box_downsample_2x2_core.sv
design/mbd_checker.sv
verif/testbench.sv
